[design/bfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

    localparam int PIXEL_W       = 8;
    localparam int PAIR_W        = PIXEL_W + 1;
    localparam int FIELDS        = 3;
    localparam int CFG_W         = 13;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_MAX    = 4096;
    localparam int SIZE_MIN      = 2;
    localparam int SIZE_RESET    = 256;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int CHANNELS_DEF  = 3;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } bfd_reg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] red_in;
        logic [PIXEL_W-1:0] green_in;
        logic [PIXEL_W-1:0] blue_in;
    } bfd_pixel_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] red_out;
        logic [PIXEL_W-1:0] green_out;
        logic [PIXEL_W-1:0] blue_out;
        logic               last_of_image;
    } bfd_result_t;

    typedef struct packed {
        logic active;
        logic load_left;
        logic load_pair;
        logic line_wr;
        logic line_rd;
        logic last;
    } bfd_scan_t;

endpackage

`default_nettype wire

[design/bfd_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfd_lane
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        restart,
    input  wire logic                        load_left,
    input  wire logic                        load_pair,
    input  wire logic [bfd_pkg::PIXEL_W-1:0] pix,
    input  wire logic [bfd_pkg::PAIR_W-1:0]  above,
    output logic      [bfd_pkg::PAIR_W-1:0]  pair,
    output logic      [bfd_pkg::PIXEL_W-1:0] avg
);

    logic [bfd_pkg::PIXEL_W-1:0] left_reg;
    logic [bfd_pkg::PAIR_W-1:0]  pair_reg;
    logic [bfd_pkg::PAIR_W:0]    block_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (restart)
        begin
            left_reg <= '0;
        end
        else if (load_left)
        begin
            left_reg <= pix;
        end
    end

    // horizontal pair of the current row
    assign pair = {1'b0, left_reg} + {1'b0, pix};

    always_ff @(posedge clk)
    begin
        if (load_pair)
        begin
            pair_reg <= pair;
        end
    end

    // pair above plus pair below, truncated divide by four
    assign block_sum = {1'b0, above} + {1'b0, pair_reg};
    assign avg       = block_sum[bfd_pkg::PAIR_W:2];

endmodule

`default_nettype wire

[design/bfd_line_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfd_line_mem
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 27
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] line_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/bfd_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfd_scan
#(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
    parameter int CW        = 12,
    parameter int AW        = 11
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      restart,
    input  wire logic                      advance,
    input  wire logic [bfd_pkg::CFG_W-1:0] width_cfg,
    input  wire logic [bfd_pkg::CFG_W-1:0] height_cfg,
    output bfd_pkg::bfd_scan_t             scan,
    output logic      [AW-1:0]             slot
);

    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(bfd_pkg::HEIGHT_MAX + 1);
    localparam int RW  = bfd_pkg::ROW_W;

    logic [WCW-1:0] w_eff;
    logic [HCW-1:0] h_eff;
    logic [CW-1:0]  col_last;
    logic [CW-1:0]  col_used_last;
    logic [RW-1:0]  row_last;
    logic [RW-1:0]  row_used_last;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  col_next;
    logic [RW-1:0]  row_reg;
    logic [RW-1:0]  row_next;
    logic           col_end;
    logic           row_end;

    always_comb
    begin
        priority if (32'(width_cfg) < 32'(bfd_pkg::SIZE_MIN))
        begin
            w_eff = WCW'(bfd_pkg::SIZE_MIN);
        end
        else if (32'(width_cfg) > 32'(MAX_WIDTH))
        begin
            w_eff = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WCW'(width_cfg);
        end
    end

    always_comb
    begin
        priority if (32'(height_cfg) < 32'(bfd_pkg::SIZE_MIN))
        begin
            h_eff = HCW'(bfd_pkg::SIZE_MIN);
        end
        else if (32'(height_cfg) > 32'(bfd_pkg::HEIGHT_MAX))
        begin
            h_eff = HCW'(bfd_pkg::HEIGHT_MAX);
        end
        else
        begin
            h_eff = HCW'(height_cfg);
        end
    end

    // last index, and last index of the even-sized part that is filtered
    assign col_last      = CW'(w_eff - WCW'(1));
    assign col_used_last = CW'({w_eff[WCW-1:1], 1'b0} - WCW'(1));
    assign row_last      = RW'(h_eff - HCW'(1));
    assign row_used_last = RW'({h_eff[HCW-1:1], 1'b0} - HCW'(1));

    assign col_end = (col_reg == col_last);
    assign row_end = (row_reg == row_last);

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        scan.active    = (col_reg <= col_used_last) && (row_reg <= row_used_last);
        scan.load_left = scan.active && !col_reg[0];
        scan.load_pair = scan.active && col_reg[0];
        scan.line_wr   = scan.load_pair && !row_reg[0];
        scan.line_rd   = scan.load_pair && row_reg[0];
        scan.last      = (col_reg == col_used_last) && (row_reg == row_used_last);
    end

    assign slot = AW'(col_reg >> 1);

endmodule

`default_nettype wire

[design/box_filter_downsample_2x2.sv]
// 2x2 box filter downsampler, one mipmap level from an rgb8 raster stream
// pixel channel: valid/ready, one source pixel per word in raster order
// result channel: valid/ready, one averaged pixel per 2x2 block, emitted
//   when the odd-column pixel of an odd row is taken; last_of_image marks
//   the final block of the level; trailing odd column and row give nothing
// apb port: register 0 source width at 0x0, register 1 source height at 0x4;
//   a write restarts the image; user writes only while the block idles, not checked
// throughput: one pixel per clock while pixel_ready is high, set by the
//   single-port-write, single-read line store holding pair sums of the even row
// path: accepting a block's last pixel loads the line store read data, the pair
//   register and the pair stage valid together, then the output register when it can move
// reset: counters clear, size 256 x 256; the line store is not cleared,
//   every entry is written on the even row before the odd row reads it
// stall: one pair stage and one output register; pixels keep flowing while
//   either can move, pixel_ready drops only when both are full
`timescale 1ns / 1ps
`default_nettype none

module box_filter_downsample_2x2
#(
    parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
    parameter int CHANNELS  = bfd_pkg::CHANNELS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pixel_valid,
    output logic                                pixel_ready,
    input  wire bfd_pkg::bfd_pixel_t            pixel,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output bfd_pkg::bfd_result_t                result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bfd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [bfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [bfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    localparam int DEPTH  = MAX_WIDTH / 2;
    localparam int CW     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW     = bfd_pkg::PAIR_W;
    localparam int LANES  = (CHANNELS < bfd_pkg::FIELDS) ? CHANNELS : bfd_pkg::FIELDS;
    localparam int LINE_W = PW * LANES;

    logic [bfd_pkg::CFG_W-1:0]   width_reg;
    logic [bfd_pkg::CFG_W-1:0]   height_reg;
    logic                        cfg_wr;
    bfd_pkg::bfd_reg_t           cfg_sel;

    bfd_pkg::bfd_scan_t          scan;
    logic [AW-1:0]               slot;
    logic                        accept;
    logic                        out_adv;

    logic [bfd_pkg::PIXEL_W-1:0] pix   [bfd_pkg::FIELDS];
    logic [bfd_pkg::PIXEL_W-1:0] avg   [bfd_pkg::FIELDS];
    logic [LINE_W-1:0]           line_wdata;
    logic [LINE_W-1:0]           line_rdata;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic                        s1_last_reg;
    logic                        out_valid_reg;
    bfd_pkg::bfd_result_t        out_reg;
    bfd_pkg::bfd_result_t        out_next;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = bfd_pkg::bfd_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bfd_pkg::CFG_W'(bfd_pkg::SIZE_RESET);
            height_reg <= bfd_pkg::CFG_W'(bfd_pkg::SIZE_RESET);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                bfd_pkg::REG_WIDTH:  width_reg  <= pwdata[bfd_pkg::CFG_W-1:0];
                bfd_pkg::REG_HEIGHT: height_reg <= pwdata[bfd_pkg::CFG_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            bfd_pkg::REG_WIDTH:  prdata = bfd_pkg::APB_DATA_W'(width_reg);
            bfd_pkg::REG_HEIGHT: prdata = bfd_pkg::APB_DATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    // handshake
    assign out_adv     = !out_valid_reg || result_ready;
    assign pixel_ready = !s1_valid_reg || out_adv;
    assign accept      = pixel_valid && pixel_ready;

    bfd_scan
    #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .AW        (AW)
    )
    u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr),
        .advance    (accept),
        .width_cfg  (width_reg),
        .height_cfg (height_reg),
        .scan       (scan),
        .slot       (slot)
    );

    assign pix[0] = pixel.red_in;
    assign pix[1] = pixel.green_in;
    assign pix[2] = pixel.blue_in;

    // one lane per colour channel
    for (genvar c = 0; c < bfd_pkg::FIELDS; c++)
    begin : g_lane
        if (c < CHANNELS)
        begin : g_on
            bfd_lane u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .restart   (cfg_wr),
                .load_left (accept && scan.load_left),
                .load_pair (accept && scan.load_pair),
                .pix       (pix[c]),
                .above     (line_rdata[c*PW +: PW]),
                .pair      (line_wdata[c*PW +: PW]),
                .avg       (avg[c])
            );
        end
        else
        begin : g_off
            assign avg[c] = '0;
        end
    end

    bfd_line_mem
    #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (LINE_W)
    )
    u_line_mem
    (
        .clk     (clk),
        .wr_en   (accept && scan.line_wr),
        .wr_addr (slot),
        .wr_data (line_wdata),
        .rd_en   (accept && scan.line_rd),
        .rd_addr (slot),
        .rd_data (line_rdata)
    );

    // pair stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !out_adv;
        if (accept)
        begin
            s1_valid_next = scan.line_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= scan.last;
        end
    end

    // merge lane averages into the result word
    always_comb
    begin
        out_next.red_out       = avg[0];
        out_next.green_out     = avg[1];
        out_next.blue_out      = avg[2];
        out_next.last_of_image = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

    import bfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_PIXELS = 750;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef enum {SET_REG, PUSH_PIXEL} script_op_t;
    typedef enum {BY_PREDICTOR, NO_BLOCK, TYPED_BLOCK} block_check_t;

    typedef struct {
        script_op_t   op;
        bfd_reg_t     sel;
        logic [31:0]  value;
        bfd_pixel_t   px;
        block_check_t how;
        bfd_result_t  blk;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  pixel_valid;
    logic                  pixel_ready;
    bfd_pixel_t            pixel;
    logic                  result_valid;
    logic                  result_ready;
    bfd_result_t           result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit [CFG_W-1:0]        width_reg = CFG_W'(SIZE_RESET);
    bit [CFG_W-1:0]        height_reg = CFG_W'(SIZE_RESET);
    bit [3*PAIR_W-1:0]     upper_pair_sums [MAX_WIDTH_DEF/2];
    bfd_pixel_t            left_held = '0;
    int unsigned           col_pos = 0;
    int unsigned           row_pos = 0;

    bfd_result_t           awaited_blocks [$];
    int unsigned           block_mismatches = 0;
    int unsigned           cycle_count = 0;
    int unsigned           random_pixels = 0;

    script_row_t script [27] = '{
        '{SET_REG,    REG_WIDTH,  32'd2, 24'h000000, NO_BLOCK,     '0},
        '{SET_REG,    REG_HEIGHT, 32'd2, 24'h000000, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFFFFFF, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFFFFFF, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFFFFFF, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFFFFFF, TYPED_BLOCK,
          '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h000000, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h000000, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h000000, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h000000, TYPED_BLOCK,
          '{8'h00, 8'h00, 8'h00, 1'b1}},
        '{SET_REG,    REG_WIDTH,  32'd0, 24'h000000, NO_BLOCK,     '0},
        '{SET_REG,    REG_HEIGHT, 32'd1, 24'h000000, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFF0001, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFF0002, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h00FF01, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h01FFFE, BY_PREDICTOR, '0},
        '{SET_REG,    REG_WIDTH,  32'd3, 24'h000000, NO_BLOCK,     '0},
        '{SET_REG,    REG_HEIGHT, 32'd3, 24'h000000, NO_BLOCK,     '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h123456, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h89ABCD, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h7F7F7F, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h808080, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h010203, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFEFDFC, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hAA55AA, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'h55AA55, BY_PREDICTOR, '0},
        '{PUSH_PIXEL, REG_WIDTH,  32'd0, 24'hFFFFFF, BY_PREDICTOR, '0}
    };

    box_filter_downsample_2x2 DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned effective_size(input bit [CFG_W-1:0] v,
                                                   input int unsigned hi);
        if (v < SIZE_MIN)
            return SIZE_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bit average_block(input bfd_pixel_t p, output bfd_result_t blk);
        int unsigned     w;
        int unsigned     h;
        int unsigned     used_w;
        int unsigned     used_h;
        int unsigned     slot;
        bit [PAIR_W-1:0] sum_r;
        bit [PAIR_W-1:0] sum_g;
        bit [PAIR_W-1:0] sum_b;
        bit [3*PAIR_W-1:0] above;
        bit              made;
        made = 1'b0;
        blk = '0;
        w = effective_size(width_reg, MAX_WIDTH_DEF);
        h = effective_size(height_reg, HEIGHT_MAX);
        used_w = w & ~32'd1;
        used_h = h & ~32'd1;
        if (col_pos < used_w && row_pos < used_h)
        begin
            if (col_pos[0] == 1'b0)
                left_held = p;
            else
            begin
                slot = col_pos >> 1;
                sum_r = left_held.red_in + p.red_in;
                sum_g = left_held.green_in + p.green_in;
                sum_b = left_held.blue_in + p.blue_in;
                if (row_pos[0] == 1'b0)
                    upper_pair_sums[slot] = {sum_r, sum_g, sum_b};
                else
                begin
                    above = upper_pair_sums[slot];
                    blk.red_out = 8'((int'(above[3*PAIR_W-1:2*PAIR_W]) + int'(sum_r)) >> 2);
                    blk.green_out = 8'((int'(above[2*PAIR_W-1:PAIR_W]) + int'(sum_g)) >> 2);
                    blk.blue_out = 8'((int'(above[PAIR_W-1:0]) + int'(sum_b)) >> 2);
                    blk.last_of_image = (col_pos == used_w - 1) && (row_pos == used_h - 1);
                    made = 1'b1;
                end
            end
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return made;
    endfunction

    function automatic bfd_pixel_t random_pixel();
        bfd_pixel_t p;
        p = 24'($urandom);
        if ($urandom_range(0, 5) == 0)
            p.red_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 5) == 0)
            p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 5) == 0)
            p.blue_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    function automatic bit [CFG_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return CFG_W'(r);
        return CFG_W'($urandom_range(2, 10));
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (awaited_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input bfd_reg_t sel, input logic [31:0] value);
        wait_idle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_WIDTH)
            width_reg = value[CFG_W-1:0];
        else
            height_reg = value[CFG_W-1:0];
        left_held = '0;
        col_pos = 0;
        row_pos = 0;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_pixel(input bfd_pixel_t p, input block_check_t how,
                              input bfd_result_t typed_blk);
        bfd_result_t blk;
        bit          made;
        @(negedge clk);
        pixel_valid <= 1'b1;
        pixel <= p;
        do @(posedge clk); while (!pixel_ready);
        made = average_block(p, blk);
        case (how)
            BY_PREDICTOR: if (made) awaited_blocks.push_back(blk);
            TYPED_BLOCK:  awaited_blocks.push_back(typed_blk);
            default:      ;
        endcase
    endtask

    task automatic send_pixels(input int unsigned count);
        int unsigned burst_left;
        int unsigned gap;
        burst_left = 0;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                         : $urandom_range(1, 20);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                if ($urandom_range(0, 15) == 0)
                    wait_idle();
                else if (gap != 0)
                begin
                    @(negedge clk);
                    pixel_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            send_pixel(random_pixel(), BY_PREDICTOR, '0);
            burst_left--;
        end
    endtask

    initial
    begin : stimulus
        bit [CFG_W-1:0] wv;
        bit [CFG_W-1:0] hv;
        int unsigned    area;
        int unsigned    n;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].op == SET_REG)
                write_size(script[i].sel, script[i].value);
            else
                send_pixel(script[i].px, script[i].how, script[i].blk);
        end

        // sizes above the maximum clamp, partial images cut short by the next write
        write_size(REG_WIDTH, 32'd8191);
        write_size(REG_HEIGHT, 32'd2);
        send_pixels(200);
        write_size(REG_WIDTH, 32'd2);
        write_size(REG_HEIGHT, 32'd8191);
        send_pixels(200);

        while (random_pixels < RANDOM_PIXELS)
        begin
            wv = pick_size();
            hv = pick_size();
            if ($urandom_range(0, 1))
            begin
                write_size(REG_WIDTH, 32'(wv));
                write_size(REG_HEIGHT, 32'(hv));
            end
            else
            begin
                write_size(REG_HEIGHT, 32'(hv));
                write_size(REG_WIDTH, 32'(wv));
            end
            area = effective_size(wv, MAX_WIDTH_DEF) * effective_size(hv, HEIGHT_MAX);
            // partial image now and then, cut short by the next register write
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, area - 1);
            else
                n = area * $urandom_range(1, 3);
            send_pixels(n);
            random_pixels += n;
        end

        wait_idle();
        if (block_mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : result_side
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 160);
            for (tick = 0; tick < span; tick++)
            begin
                @(negedge clk);
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    2:       result_ready <= (tick % 5) != 4;
                    default: result_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // each result word against the oldest awaited block
    always @(posedge clk)
    begin : check_results
        bfd_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_blocks.size() == 0)
            begin
                if (block_mismatches < 10)
                    $display("unexpected result word r=%02h g=%02h b=%02h last=%0d",
                             result.red_out, result.green_out, result.blue_out,
                             result.last_of_image);
                block_mismatches++;
            end
            else
            begin
                want = awaited_blocks.pop_front();
                if (result.red_out !== want.red_out || result.green_out !== want.green_out
                    || result.blue_out !== want.blue_out
                    || result.last_of_image !== want.last_of_image)
                begin
                    if (block_mismatches < 10)
                        $display({"mismatch: expected r=%02h g=%02h b=%02h last=%0d, ",
                                  "got r=%02h g=%02h b=%02h last=%0d"},
                                 want.red_out, want.green_out, want.blue_out,
                                 want.last_of_image, result.red_out, result.green_out,
                                 result.blue_out, result.last_of_image);
                    block_mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

[filelist.f]
design/bfd_pkg.sv
design/bfd_lane.sv
design/bfd_line_mem.sv
design/bfd_scan.sv
design/box_filter_downsample_2x2.sv
verif/tb.sv
